// ===== hw/rtl/nearest_palette_color_index_assert.svh =====
`ifndef NEAREST_PALETTE_COLOR_INDEX_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
`define NPCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPCI_ASSERT(lbl, prop, msg)
`define NPCI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/npci_pkg.sv =====
package npci_pkg;

  localparam int DIST_W = 18;

  localparam logic [63:0] Q30_ONE  = 64'd1073741824;
  localparam logic [63:0] HUE6_Q30 = 64'd4295182044;
  localparam logic [63:0] K1  = 64'd1686629713;
  localparam logic [63:0] K3  = 64'd693598668;
  localparam logic [63:0] K5  = 64'd85569306;
  localparam logic [63:0] K7  = 64'd5026995;
  localparam logic [63:0] K9  = 64'd172272;
  localparam logic [63:0] K11 = 64'd3864;

  localparam int COORD_BASE = 64881;
  localparam int COORD_MIN  = -65536;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } sq_t;

  typedef enum logic [2:0] {
    SECT_GREEN_UP,
    SECT_RED_DOWN,
    SECT_BLUE_UP,
    SECT_GREEN_DOWN,
    SECT_RED_UP
  } sector_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  function automatic sq_t pix_squares(input pix_t p, input logic [23:0] entry);
    sq_t s;
    s.red   = sq_diff(p.red,   entry[23:16]);
    s.green = sq_diff(p.green, entry[15:8]);
    s.blue  = sq_diff(p.blue,  entry[7:0]);
    return s;
  endfunction

  function automatic logic [7:0] warp_channel(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] b;
    logic [7:0]  res;
    x2 = (x * x) >> 30;
    p  = K11;
    p  = K9 - ((x2 * p) >> 30);
    p  = K7 - ((x2 * p) >> 30);
    p  = K5 - ((x2 * p) >> 30);
    p  = K3 - ((x2 * p) >> 30);
    p  = K1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    q  = (s * s) >> 30;
    b  = (64'd255 * q) >> 30;
    if (x == 64'd0) begin
      res = 8'h00;
    end else if (x >= Q30_ONE) begin
      res = 8'hFF;
    end else if (b > 64'd255) begin
      res = 8'hFF;
    end else begin
      res = b[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/nearest_palette_color_index.sv =====
// Nearest palette color search: each RGB byte triple is matched against a fixed
// palette of PALETTE_ENTRIES colors (a hue sweep from blue to red, warped per
// channel) and returns the index of the closest entry by squared distance, lowest
// index on ties, that distance, and the Q16 coordinate 0.99 - index/256
// (saturated at -1.0). One color is taken every clock while the output is not
// held; each color passes through the input register, one registered compare
// cell per palette entry and the output register. When the output is held, the
// whole chain holds and input ready drops.
`include "nearest_palette_color_index_assert.svh"

module nearest_palette_color_index #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_red_in,
  input  logic [7:0]                   in_green_in,
  input  logic [7:0]                   in_blue_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_best_index,
  output logic [npci_pkg::DIST_W-1:0]  out_best_distance_sq,
  output logic signed [16:0]           out_lut_coordinate
);
  import npci_pkg::*;

  localparam int          IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam logic [63:0] PalLast = 64'(PALETTE_ENTRIES - 1);

  function automatic logic [23:0] make_entry(input int unsigned idx);
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] g;
    logic [63:0] b;
    sector_t     sec;
    t   = (HUE6_Q30 * (PalLast - 64'(idx))) / PalLast;
    f   = t & (Q30_ONE - 64'd1);
    sec = sector_t'(t[32:30]);
    case (sec)
      SECT_GREEN_UP: begin
        r = Q30_ONE;
        g = f;
        b = 64'd0;
      end
      SECT_RED_DOWN: begin
        r = Q30_ONE - f;
        g = Q30_ONE;
        b = 64'd0;
      end
      SECT_BLUE_UP: begin
        r = 64'd0;
        g = Q30_ONE;
        b = f;
      end
      SECT_GREEN_DOWN: begin
        r = 64'd0;
        g = Q30_ONE - f;
        b = Q30_ONE;
      end
      default: begin
        r = f;
        g = 64'd0;
        b = Q30_ONE;
      end
    endcase
    return {warp_channel(r), warp_channel(g), warp_channel(b)};
  endfunction

  localparam logic [23:0] EntryZero = make_entry(0);

  logic              advance;
  logic              in_valid_r;
  pix_t              pix0_r;
  sq_t               sq0_r;
  pix_t              pix_in;

  logic              valid_c [PALETTE_ENTRIES+1];
  pix_t              pix_c   [PALETTE_ENTRIES+1];
  sq_t               sq_c    [PALETTE_ENTRIES+1];
  logic [IDX_W-1:0]  best_c  [PALETTE_ENTRIES+1];
  logic [DIST_W-1:0] dist_c  [PALETTE_ENTRIES+1];

  assign in_ready = advance;
  assign pix_in   = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix0_r <= pix_in;
      sq0_r  <= pix_squares(pix_in, EntryZero);
    end
  end

  assign valid_c[0] = in_valid_r;
  assign pix_c[0]   = pix0_r;
  assign sq_c[0]    = sq0_r;
  assign best_c[0]  = '0;
  assign dist_c[0]  = '0;

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    localparam int          NextIdx = (k + 1) % PALETTE_ENTRIES;
    localparam logic [23:0] NextRgb = make_entry(NextIdx);

    npci_cell #(
      .IDX_W    (IDX_W),
      .INDEX    (k),
      .NEXT_RGB (NextRgb)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .valid_i (valid_c[k]),
      .pix_i   (pix_c[k]),
      .sq_i    (sq_c[k]),
      .best_i  (best_c[k]),
      .dist_i  (dist_c[k]),
      .valid_o (valid_c[k+1]),
      .pix_o   (pix_c[k+1]),
      .sq_o    (sq_c[k+1]),
      .best_o  (best_c[k+1]),
      .dist_o  (dist_c[k+1])
    );
  end

  npci_out #(
    .IDX_W (IDX_W)
  ) u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .valid_i              (valid_c[PALETTE_ENTRIES]),
    .best_i               (best_c[PALETTE_ENTRIES]),
    .dist_i               (dist_c[PALETTE_ENTRIES]),
    .out_ready            (out_ready),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_best_index       (out_best_index),
    .out_best_distance_sq (out_best_distance_sq),
    .out_lut_coordinate   (out_lut_coordinate)
  );

  `NPCI_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `NPCI_ASSERT(a_ready_tracks_out, in_ready == (!out_valid || out_ready), "ready mismatch")
  `NPCI_ASSERT(a_transfer_enters, in_valid && in_ready |=> in_valid_r, "transfer lost at entry")
  `NPCI_ASSERT(a_dist_bound, out_valid |-> out_best_distance_sq <= 18'd195075, "distance range")

endmodule

// ===== hw/rtl/npci_cell.sv =====
module npci_cell #(
  parameter int          IDX_W    = 8,
  parameter int          INDEX    = 0,
  parameter logic [23:0] NEXT_RGB = 24'h000000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         valid_i,
  input  npci_pkg::pix_t               pix_i,
  input  npci_pkg::sq_t                sq_i,
  input  logic [IDX_W-1:0]             best_i,
  input  logic [npci_pkg::DIST_W-1:0]  dist_i,
  output logic                         valid_o,
  output npci_pkg::pix_t               pix_o,
  output npci_pkg::sq_t                sq_o,
  output logic [IDX_W-1:0]             best_o,
  output logic [npci_pkg::DIST_W-1:0]  dist_o
);
  import npci_pkg::*;

  localparam bit First = (INDEX == 0);

  logic [DIST_W-1:0] dist_sum;
  logic              take;
  logic              valid_r;
  pix_t              pix_r;
  sq_t               sq_r;
  sq_t               sq_nxt;
  logic [IDX_W-1:0]  best_r;
  logic [IDX_W-1:0]  best_nxt;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] dist_nxt;

  assign dist_sum = DIST_W'(sq_i.red) + DIST_W'(sq_i.green) + DIST_W'(sq_i.blue);
  assign take     = First || (dist_sum < dist_i);
  assign best_nxt = take ? IDX_W'(INDEX) : best_i;
  assign dist_nxt = take ? dist_sum : dist_i;
  assign sq_nxt   = pix_squares(pix_i, NEXT_RGB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_r  <= pix_i;
      sq_r   <= sq_nxt;
      best_r <= best_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;
  assign sq_o    = sq_r;
  assign best_o  = best_r;
  assign dist_o  = dist_r;

endmodule

// ===== hw/rtl/npci_out.sv =====
module npci_out #(
  parameter int IDX_W = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  input  logic [IDX_W-1:0]             best_i,
  input  logic [npci_pkg::DIST_W-1:0]  dist_i,
  input  logic                         out_ready,
  output logic                         advance,
  output logic                         out_valid,
  output logic [7:0]                   out_best_index,
  output logic [npci_pkg::DIST_W-1:0]  out_best_distance_sq,
  output logic signed [16:0]           out_lut_coordinate
);
  import npci_pkg::*;

  localparam int CW = IDX_W + 18;
  localparam logic signed [CW-1:0] CoordBase = CW'(COORD_BASE);
  localparam logic signed [CW-1:0] CoordMin  = CW'(COORD_MIN);

  logic signed [CW-1:0] coord_full;
  logic signed [16:0]   coord_nxt;
  logic                 valid_r;
  logic [7:0]           index_r;
  logic [DIST_W-1:0]    dist_r;
  logic signed [16:0]   coord_r;

  assign coord_full = CoordBase - $signed(CW'({best_i, 8'h00}));
  assign coord_nxt  = (coord_full < CoordMin) ? CoordMin[16:0] : coord_full[16:0];
  assign advance    = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      index_r <= 8'(best_i);
      dist_r  <= dist_i;
      coord_r <= coord_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_best_index       = index_r;
  assign out_best_distance_sq = dist_r;
  assign out_lut_coordinate   = coord_r;

endmodule

// ===== test/nearest_palette_color_index_tb.sv =====
`default_nettype none

module nearest_palette_color_index_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npci_pkg::*;

  localparam int ENTRIES     = 256;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = ENTRIES + 40;

  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] HUE_SPAN   = 64'd4295182044;
  localparam logic [63:0] SIN_C1     = 64'd1686629713;
  localparam logic [63:0] SIN_C3     = 64'd693598668;
  localparam logic [63:0] SIN_C5     = 64'd85569306;
  localparam logic [63:0] SIN_C7     = 64'd5026995;
  localparam logic [63:0] SIN_C9     = 64'd172272;
  localparam logic [63:0] SIN_C11    = 64'd3864;
  localparam int          COORD_TOP  = 64881;
  localparam int          COORD_FLOOR = -65536;

  typedef struct {
    logic [7:0]         idx;
    logic [17:0]        dist_sq;
    logic signed [16:0] coord;
  } match_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_red_in = 8'd0;
  logic [7:0]                  in_green_in = 8'd0;
  logic [7:0]                  in_blue_in = 8'd0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_best_index;
  logic [npci_pkg::DIST_W-1:0] out_best_distance_sq;
  logic signed [16:0]          out_lut_coordinate;

  logic [23:0] palette_color [0:ENTRIES-1];
  pix_t        pending_colors[$];
  match_t      expected_matches[$];
  match_t      head_match;
  int          sent_count = 0;
  int          got_count = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  nearest_palette_color_index #(
    .PALETTE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_red_in            (in_red_in),
    .in_green_in          (in_green_in),
    .in_blue_in           (in_blue_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_best_index       (out_best_index),
    .out_best_distance_sq (out_best_distance_sq),
    .out_lut_coordinate   (out_lut_coordinate)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] sine_sq_byte(input logic [63:0] x);
    logic [63:0] coef [0:5];
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] b;
    coef = '{SIN_C11, SIN_C9, SIN_C7, SIN_C5, SIN_C3, SIN_C1};
    if (x == 64'd0) return 8'h00;
    if (x >= ONE_Q30) return 8'hFF;
    x2  = (x * x) >> 30;
    acc = coef[0];
    for (int k = 1; k < 6; k++) begin
      acc = coef[k] - ((x2 * acc) >> 30);
    end
    s = (x * acc) >> 30;
    q = (s * s) >> 30;
    b = (64'd255 * q) >> 30;
    return (b > 64'd255) ? 8'hFF : b[7:0];
  endfunction

  function automatic logic [23:0] hue_entry(input int unsigned i);
    logic [63:0] span;
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] g;
    logic [63:0] b;
    sector_t     sec;
    span = (ENTRIES > 1) ? 64'(ENTRIES - 1) : 64'd1;
    t    = (HUE_SPAN * (span - 64'(i))) / span;
    sec  = sector_t'(t[32:30]);
    f    = {34'd0, t[29:0]};
    r    = 64'd0;
    g    = 64'd0;
    b    = 64'd0;
    case (sec)
      SECT_GREEN_UP: begin
        r = ONE_Q30;
        g = f;
      end
      SECT_RED_DOWN: begin
        r = ONE_Q30 - f;
        g = ONE_Q30;
      end
      SECT_BLUE_UP: begin
        g = ONE_Q30;
        b = f;
      end
      SECT_GREEN_DOWN: begin
        g = ONE_Q30 - f;
        b = ONE_Q30;
      end
      default: begin
        r = f;
        b = ONE_Q30;
      end
    endcase
    return {sine_sq_byte(r), sine_sq_byte(g), sine_sq_byte(b)};
  endfunction

  function automatic match_t nearest_match(input pix_t c);
    match_t      m;
    int unsigned best_d;
    int unsigned d;
    int          dr;
    int          dg;
    int          db;
    int          best;
    int          coord;
    best_d = 32'hFFFF_FFFF;
    best   = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      dr = int'(palette_color[i][23:16]) - int'(c.red);
      dg = int'(palette_color[i][15:8]) - int'(c.green);
      db = int'(palette_color[i][7:0]) - int'(c.blue);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    coord = COORD_TOP - best * 256;
    if (coord < COORD_FLOOR) coord = COORD_FLOOR;
    m.idx     = best[7:0];
    m.dist_sq = best_d[17:0];
    m.coord   = coord[16:0];
    return m;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] v);
    int n;
    n = int'(v) + int'($urandom_range(12)) - 6;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return n[7:0];
  endfunction

  function automatic bit take_break(input bit quiet);
    return !quiet && ($urandom_range(99) < 34);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_colors.size() != 0 && !take_break(sent_count >= 200 && sent_count < 330)) begin
        in_red_in   <= pending_colors[0].red;
        in_green_in <= pending_colors[0].green;
        in_blue_in  <= pending_colors[0].blue;
        pending_colors.delete(0);
        in_valid    <= 1'b1;
        sent_count  <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break(got_count >= 150 && got_count < 300);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_matches.insert(expected_matches.size(),
                                nearest_match('{in_red_in, in_green_in, in_blue_in}));
      end
      if (out_valid && out_ready) begin
        got_count <= got_count + 1;
        if (expected_matches.size() == 0) begin
          report_mismatch("result transfer with no input pending");
        end else begin
          head_match = expected_matches.pop_front();
          if (out_best_index !== head_match.idx)
            report_mismatch($sformatf("best_index got %0d want %0d",
                                      out_best_index, head_match.idx));
          if (out_best_distance_sq !== head_match.dist_sq)
            report_mismatch($sformatf("best_distance_sq got %0d want %0d",
                                      out_best_distance_sq, head_match.dist_sq));
          if (out_lut_coordinate !== head_match.coord)
            report_mismatch($sformatf("lut_coordinate got %0d want %0d",
                                      out_lut_coordinate, head_match.coord));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int   ties;
    int   dups;
    int   k;
    pix_t c;
    logic [23:0] a;
    logic [23:0] b;

    for (int i = 0; i < ENTRIES; i++) begin
      palette_color[i] = hue_entry(i);
    end

    pending_colors.insert(pending_colors.size(), '{8'h00, 8'h00, 8'h00});
    pending_colors.insert(pending_colors.size(), '{8'hFF, 8'hFF, 8'hFF});
    pending_colors.insert(pending_colors.size(), '{8'hFF, 8'h00, 8'h00});
    pending_colors.insert(pending_colors.size(), '{8'h00, 8'hFF, 8'h00});
    pending_colors.insert(pending_colors.size(), '{8'h00, 8'h00, 8'hFF});
    pending_colors.insert(pending_colors.size(), '{8'hFF, 8'hFF, 8'h00});
    pending_colors.insert(pending_colors.size(), '{8'h00, 8'hFF, 8'hFF});
    pending_colors.insert(pending_colors.size(), '{8'hFF, 8'h00, 8'hFF});
    pending_colors.insert(pending_colors.size(), '{8'h80, 8'h7F, 8'h80});
    pending_colors.insert(pending_colors.size(), palette_color[0]);
    pending_colors.insert(pending_colors.size(), palette_color[ENTRIES/2]);
    pending_colors.insert(pending_colors.size(), palette_color[ENTRIES-1]);
    pending_colors.insert(pending_colors.size(), '{8'h55, 8'hAA, 8'h55});

    ties = 0;
    dups = 0;
    for (int i = 1; i < ENTRIES; i++) begin
      a = palette_color[i-1];
      b = palette_color[i];
      if (a == b && dups < 4) begin
        pending_colors.insert(pending_colors.size(), b);
        dups++;
      end else if (ties < 6) begin
        k = 0;
        for (int ch = 0; ch < 3; ch++) begin
          if (a[ch*8 +: 8] != b[ch*8 +: 8]) k++;
        end
        if (k == 1 && (((a ^ b) & 24'h010101) == 24'd0)) begin
          c = '{8'((9'(a[23:16]) + 9'(b[23:16])) >> 1),
                8'((9'(a[15:8]) + 9'(b[15:8])) >> 1),
                8'((9'(a[7:0]) + 9'(b[7:0])) >> 1)};
          pending_colors.insert(pending_colors.size(), c);
          ties++;
        end
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = $urandom_range(9);
      if (k < 4) begin
        c = pix_t'(24'($urandom));
      end else if (k < 8) begin
        b = palette_color[$urandom_range(ENTRIES-1)];
        c = '{jitter(b[23:16]), jitter(b[15:8]), jitter(b[7:0])};
      end else begin
        c = pix_t'(24'($urandom));
        if ($urandom_range(1)) c.red = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(1)) c.green = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(1)) c.blue = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      pending_colors.insert(pending_colors.size(), c);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_colors.size() != 0 || in_valid) @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
